// ----- hw/rtl/dclrle_pkg.sv -----
// ----------------------------------------------------------------------------
// dclrle_pkg
// Types, constants and helpers for the DEFLATE code-length run-length coder.
// ----------------------------------------------------------------------------
package dclrle_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] MAX_ZERO_RUN   = 8'd138;
  localparam logic [7:0] MAX_REPEAT_RUN = 8'd6;

  localparam logic [4:0] SYM_REPEAT   = 5'd16;
  localparam logic [4:0] SYM_ZERO_SH  = 5'd17;
  localparam logic [4:0] SYM_ZERO_LG  = 5'd18;
  localparam logic [4:0] NO_SYMBOL    = 5'd31;

  localparam logic [2:0] XBITS_REPEAT  = 3'd2;
  localparam logic [2:0] XBITS_ZERO_SH = 3'd3;
  localparam logic [2:0] XBITS_ZERO_LG = 3'd7;

  typedef struct packed {
    logic [3:0] clen;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [4:0] symbol;
    logic [6:0] extra_value;
    logic [2:0] extra_bits;
    logic       end_of_table;
  } out_t;

  function automatic out_t lit_sym(input logic [3:0] value);
    out_t r;
    r.symbol       = {1'b0, value};
    r.extra_value  = '0;
    r.extra_bits   = '0;
    r.end_of_table = 1'b0;
    return r;
  endfunction

  // run of three or more
  function automatic out_t run_sym(input logic [3:0] value, input logic [7:0] count);
    out_t       r;
    logic [7:0] d3;
    logic [7:0] d11;
    d3  = count - 8'd3;
    d11 = count - 8'd11;
    r.end_of_table = 1'b0;
    if (value != 4'd0) begin
      r.symbol      = SYM_REPEAT;
      r.extra_value = d3[6:0];
      r.extra_bits  = XBITS_REPEAT;
    end else if (count <= 8'd10) begin
      r.symbol      = SYM_ZERO_SH;
      r.extra_value = d3[6:0];
      r.extra_bits  = XBITS_ZERO_SH;
    end else begin
      r.symbol      = SYM_ZERO_LG;
      r.extra_value = d11[6:0];
      r.extra_bits  = XBITS_ZERO_LG;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/deflate_code_length_rle_core.sv -----
// ----------------------------------------------------------------------------
// deflate_code_length_rle_core
// Run-length coder turning code lengths into DEFLATE code-length symbols.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one code length per
// transaction; in_data.last closes the table. Output channel
// (out_valid/out_stall/out_data) gives code-length symbols with their extra
// bits; end_of_table marks the final symbol of a table.
// An item is coded in the cycle it is accepted and its symbols (none, one,
// two or three) sit in a result register from the next cycle on. One item is
// taken per cycle while each item yields at most one symbol and out_stall is
// low; an item yielding several symbols keeps the next one waiting until the
// single output port has drained the result register.
// Symbols of a run are held back until the run ends or is cut (16 at six
// copies, 18 at 138 zeros), so an item may yield nothing.
// The input is taken in the same cycle as the last pending symbol leaves.
// While out_stall is high the pending symbol stays put and in_stall stays
// high.
// Reset empties the result register and clears the run state (no symbol sent,
// no run pending).
// ----------------------------------------------------------------------------
module deflate_code_length_rle_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dclrle_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dclrle_pkg::out_t  out_data
);
  import dclrle_pkg::*;

  logic [4:0]           prev_r, prev_nxt;
  logic [3:0]           rv_r, rv_nxt;
  logic [7:0]           rc_r, rc_nxt;
  out_t                 bank_r [MAX_RESULTS];
  out_t                 res [MAX_RESULTS];
  logic [RES_CNT_W-1:0] cnt_r, k;
  logic [RES_IDX_W-1:0] idx_r;
  logic                 in_acc, out_acc;
  logic [3:0]           v;

  assign out_valid = ({1'b0, idx_r} != cnt_r);
  assign out_data  = bank_r[idx_r];
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = !(({1'b0, idx_r} == cnt_r) ||
                       ((RES_CNT_W'(idx_r) + 1'b1 == cnt_r) && !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign v         = in_data.clen;

  always_comb begin
    prev_nxt = prev_r;
    rv_nxt   = rv_r;
    rc_nxt   = rc_r;
    k        = '0;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = lit_sym(4'd0);

    if (rc_nxt != 8'd0 && rv_nxt != v) begin
      if (rc_nxt < 8'd3) begin
        res[k[RES_IDX_W-1:0]] = lit_sym(rv_nxt);
        k = k + 1'b1;
        if (rc_nxt == 8'd2) begin
          res[k[RES_IDX_W-1:0]] = lit_sym(rv_nxt);
          k = k + 1'b1;
        end
        prev_nxt = {1'b0, rv_nxt};
      end else begin
        res[k[RES_IDX_W-1:0]] = run_sym(rv_nxt, rc_nxt);
        prev_nxt = res[k[RES_IDX_W-1:0]].symbol;
        k = k + 1'b1;
      end
      rc_nxt = 8'd0;
    end

    if (v == 4'd0) begin
      rv_nxt = 4'd0;
      rc_nxt = rc_nxt + 8'd1;
      if (rc_nxt >= MAX_ZERO_RUN) begin
        res[k[RES_IDX_W-1:0]] = run_sym(4'd0, rc_nxt);
        prev_nxt = res[k[RES_IDX_W-1:0]].symbol;
        k = k + 1'b1;
        rc_nxt = 8'd0;
      end
    end else if (prev_nxt == {1'b0, v}) begin
      rv_nxt = v;
      rc_nxt = rc_nxt + 8'd1;
      if (rc_nxt >= MAX_REPEAT_RUN) begin
        res[k[RES_IDX_W-1:0]] = run_sym(v, rc_nxt);
        prev_nxt = res[k[RES_IDX_W-1:0]].symbol;
        k = k + 1'b1;
        rc_nxt = 8'd0;
      end
    end else begin
      res[k[RES_IDX_W-1:0]] = lit_sym(v);
      k = k + 1'b1;
      prev_nxt = {1'b0, v};
      rv_nxt = v;
      rc_nxt = 8'd0;
    end

    if (in_data.last) begin
      if (rc_nxt != 8'd0) begin
        if (rc_nxt < 8'd3) begin
          res[k[RES_IDX_W-1:0]] = lit_sym(rv_nxt);
          k = k + 1'b1;
          if (rc_nxt == 8'd2) begin
            res[k[RES_IDX_W-1:0]] = lit_sym(rv_nxt);
            k = k + 1'b1;
          end
        end else begin
          res[k[RES_IDX_W-1:0]] = run_sym(rv_nxt, rc_nxt);
          k = k + 1'b1;
        end
      end
      if (k != '0) res[RES_IDX_W'(k - 1'b1)].end_of_table = 1'b1;
      prev_nxt = NO_SYMBOL;
      rv_nxt   = 4'd0;
      rc_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= NO_SYMBOL;
      rv_r   <= 4'd0;
      rc_r   <= 8'd0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else if (in_acc) begin
      prev_r <= prev_nxt;
      rv_r   <= rv_nxt;
      rc_r   <= rc_nxt;
      cnt_r  <= k;
      idx_r  <= '0;
    end else if (out_acc) begin
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RESULTS; i++) bank_r[i] <= res[i];
    end
  end

endmodule

// ----- hw/rtl/dclrle_checker.sv -----
// ----------------------------------------------------------------------------
// dclrle_checker
// Port-level checks for the code-length run-length coder.
// ----------------------------------------------------------------------------
module dclrle_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dclrle_pkg::out_t  out_data
);
  import dclrle_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled transaction dropped or changed");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_sym_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.symbol < SYM_REPEAT && out_data.extra_bits == 3'd0 &&
       out_data.extra_value == 7'd0) ||
      (out_data.symbol == SYM_REPEAT && out_data.extra_bits == XBITS_REPEAT &&
       out_data.extra_value < 7'd4) ||
      (out_data.symbol == SYM_ZERO_SH && out_data.extra_bits == XBITS_ZERO_SH &&
       out_data.extra_value < 7'd8) ||
      (out_data.symbol == SYM_ZERO_LG && out_data.extra_bits == XBITS_ZERO_LG))
    else $error("symbol and extra bits disagree");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result pending straight after reset");

endmodule

bind deflate_code_length_rle_core dclrle_checker u_dclrle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
